/* rtl/agr_pkg.sv */
// Shared constants, types and the exp2 root table for the gamma resolve core.
package agr_pkg;

  localparam int SUM_W    = 32;
  localparam int CNT_W    = 16;
  localparam int GAMMA_W  = 12;
  localparam int GAMMA_FRAC = 10;
  localparam int SUM_FRAC = 16;
  localparam int LOG_FRAC = 24;
  localparam int LOG_INT_W = 5;
  localparam int LOG_W    = LOG_INT_W + LOG_FRAC;
  localparam int CFG_W    = 16;
  localparam int CODE_W   = 8;
  localparam int LANE_LAT = 52;

  localparam logic CFG_IDX_SAMPLE = 1'b0;
  localparam logic CFG_IDX_GAMMA  = 1'b1;

  typedef struct packed {
    logic force_en;
    logic force_val;
  } lane_ctl_t;

  typedef logic [31:0] rom_t [0:LOG_FRAC];

  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] b;
    n = n_in;
    res = 64'd0;
    b = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (b > n) b = b >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (b != 64'd0) begin
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
    end
    return res;
  endfunction

  function automatic rom_t build_root_rom();
    rom_t r;
    logic [63:0] v;
    v = 64'd1 << 31;
    r[0] = v[31:0];
    for (int i = 1; i <= LOG_FRAC; i++) begin
      v = isqrt64(v << 30);
      r[i] = v[31:0];
    end
    return r;
  endfunction

  localparam rom_t ROOT_ROM = build_root_rom();

endpackage

/* rtl/accumulation_gamma_resolve_core.sv */
// Top level of the accumulation buffer resolve with gamma correction.
// A request is taken in every clock cycle (busy stays low), and its result
// appears on the out_ ports together with out_strobe; the receiver cannot
// stall. The depth is set by the two 24-step fixed-point pipelines, log2 by
// repeated squaring and exp2 by root factors, each one multiplier per stage.
// Three channel lanes run side by side with a shared log2 of the sample
// count, and the output register merges them.
module accumulation_gamma_resolve_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [agr_pkg::SUM_W-1:0]    in_red_sum,
  input  logic [agr_pkg::SUM_W-1:0]    in_green_sum,
  input  logic [agr_pkg::SUM_W-1:0]    in_blue_sum,
  output logic                         out_strobe,
  output logic [agr_pkg::CODE_W-1:0]   out_red_byte,
  output logic [agr_pkg::CODE_W-1:0]   out_green_byte,
  output logic [agr_pkg::CODE_W-1:0]   out_blue_byte,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [agr_pkg::CFG_W-1:0]    cfg_wdata
);
  import agr_pkg::*;

  logic [CNT_W-1:0]   sample_total_r;
  logic [GAMMA_W-1:0] gamma_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_total_r <= CNT_W'(1);
      gamma_r <= GAMMA_W'(1024);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_SAMPLE: sample_total_r <= cfg_wdata[CNT_W-1:0];
        CFG_IDX_GAMMA:  gamma_r <= cfg_wdata[GAMMA_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  function automatic lane_ctl_t make_ctl(input logic [SUM_W-1:0] s,
                                         input logic [CNT_W-1:0] c,
                                         input logic [GAMMA_W-1:0] g);
    lane_ctl_t r;
    r.force_en = 1'b1;
    if (c == '0) begin
      r.force_val = (s != '0);
    end else if (g == '0) begin
      r.force_val = 1'b1;
    end else if (s == '0) begin
      r.force_val = 1'b0;
    end else begin
      r.force_en = 1'b0;
      r.force_val = 1'b0;
    end
    return r;
  endfunction

  logic [SUM_W-1:0]   sum_r [0:2];
  lane_ctl_t          ctl_r [0:2];
  logic [CNT_W-1:0]   cnt_r;
  logic [GAMMA_W-1:0] g_r;

  always_ff @(posedge clk) begin
    sum_r[0] <= in_red_sum;
    sum_r[1] <= in_green_sum;
    sum_r[2] <= in_blue_sum;
    ctl_r[0] <= make_ctl(in_red_sum, sample_total_r, gamma_r);
    ctl_r[1] <= make_ctl(in_green_sum, sample_total_r, gamma_r);
    ctl_r[2] <= make_ctl(in_blue_sum, sample_total_r, gamma_r);
    cnt_r <= sample_total_r;
    g_r <= gamma_r;
  end

  logic [LOG_W-1:0] log_cnt;

  agr_log2 u_log_cnt (
    .clk   (clk),
    .x     (SUM_W'(cnt_r)),
    .log_q (log_cnt)
  );

  logic [CODE_W-1:0] code [0:2];

  for (genvar c = 0; c < 3; c++) begin : g_lane
    agr_lane u_lane (
      .clk     (clk),
      .sum     (sum_r[c]),
      .ctl     (ctl_r[c]),
      .gamma   (g_r),
      .log_cnt (log_cnt),
      .code    (code[c])
    );
  end

  logic [LANE_LAT:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LANE_LAT-1:0], accept};
    end
  end

  logic              out_strobe_r;
  logic [CODE_W-1:0] out_red_r;
  logic [CODE_W-1:0] out_green_r;
  logic [CODE_W-1:0] out_blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= vld_r[LANE_LAT];
    end
    out_red_r   <= code[0];
    out_green_r <= code[1];
    out_blue_r  <= code[2];
  end

  assign out_strobe     = out_strobe_r;
  assign out_red_byte   = out_red_r;
  assign out_green_byte = out_green_r;
  assign out_blue_byte  = out_blue_r;

endmodule

/* rtl/agr_log2.sv */
// Pipelined fixed-point log2 unit: normalize, then one squaring step per stage.
module agr_log2 (
  input  logic                       clk,
  input  logic [agr_pkg::SUM_W-1:0]  x,
  output logic [agr_pkg::LOG_W-1:0]  log_q
);
  import agr_pkg::*;

  logic [31:0]          m_r [0:LOG_FRAC];
  logic [LOG_FRAC-1:0]  f_r [0:LOG_FRAC];
  logic [LOG_INT_W-1:0] e_r [0:LOG_FRAC];

  logic [LOG_INT_W-1:0] e_nxt;
  logic [31:0]          m_nxt;

  always_comb begin
    e_nxt = '0;
    for (int i = 0; i < SUM_W; i++) begin
      if (x[i]) e_nxt = LOG_INT_W'(i);
    end
    m_nxt = x << (5'd31 - e_nxt);
  end

  always_ff @(posedge clk) begin
    m_r[0] <= m_nxt;
    e_r[0] <= e_nxt;
    f_r[0] <= '0;
  end

  for (genvar k = 1; k <= LOG_FRAC; k++) begin : g_sq
    logic [63:0] prod;
    logic [32:0] q;
    assign prod = 64'(m_r[k-1]) * 64'(m_r[k-1]);
    assign q = prod[63:31];
    always_ff @(posedge clk) begin
      e_r[k] <= e_r[k-1];
      if (q[32]) begin
        m_r[k] <= q[32:1];
        f_r[k] <= f_r[k-1] | (LOG_FRAC'(1) << (LOG_FRAC - k));
      end else begin
        m_r[k] <= q[31:0];
        f_r[k] <= f_r[k-1];
      end
    end
  end

  assign log_q = {e_r[LOG_FRAC], f_r[LOG_FRAC]};

endmodule

/* rtl/agr_lane.sv */
// One channel lane: log2 of the sum, gamma scaling and pipelined exp2 to a display code.
module agr_lane (
  input  logic                          clk,
  input  logic [agr_pkg::SUM_W-1:0]     sum,
  input  agr_pkg::lane_ctl_t            ctl,
  input  logic [agr_pkg::GAMMA_W-1:0]   gamma,
  input  logic [agr_pkg::LOG_W-1:0]     log_cnt,
  output logic [agr_pkg::CODE_W-1:0]    code
);
  import agr_pkg::*;

  localparam logic [27:0] LIM = 28'd1 << 27;

  logic [LOG_W-1:0] log_sum;
  lane_ctl_t        ctl_d_r [0:LOG_FRAC];
  logic [GAMMA_W-1:0] g_d_r [0:LOG_FRAC];

  agr_log2 u_log2 (
    .clk   (clk),
    .x     (sum),
    .log_q (log_sum)
  );

  always_ff @(posedge clk) begin
    ctl_d_r[0] <= ctl;
    g_d_r[0] <= gamma;
    for (int k = 1; k <= LOG_FRAC; k++) begin
      ctl_d_r[k] <= ctl_d_r[k-1];
      g_d_r[k] <= g_d_r[k-1];
    end
  end

  // Log difference and overflow check.
  logic signed [30:0] d;
  logic [29:0]        negd_r;
  logic               sat_a_r;
  lane_ctl_t          ctl_a_r;
  logic [GAMMA_W-1:0] g_a_r;

  assign d = signed'({2'b00, log_sum}) - signed'({2'b00, log_cnt})
           - signed'(31'(SUM_FRAC) <<< LOG_FRAC);

  always_ff @(posedge clk) begin
    negd_r  <= 30'(-d);
    sat_a_r <= !d[30];
    ctl_a_r <= ctl_d_r[LOG_FRAC];
    g_a_r   <= g_d_r[LOG_FRAC];
  end

  // Gamma scaling.
  logic [41:0] tprod;
  logic [31:0] t;
  logic [27:0] w_r;
  logic        sat_b_r;
  logic        zero_b_r;
  lane_ctl_t   ctl_b_r;

  assign tprod = 42'(g_a_r) * 42'(negd_r);
  assign t = tprod[41:GAMMA_FRAC];

  always_ff @(posedge clk) begin
    w_r      <= LIM - t[27:0];
    zero_b_r <= t > 32'(LIM);
    sat_b_r  <= sat_a_r;
    ctl_b_r  <= ctl_a_r;
  end

  // exp2 of the fraction, one root factor per stage.
  logic [31:0] p_r      [1:LOG_FRAC];
  logic [27:0] we_r     [1:LOG_FRAC];
  logic        sat_e_r  [1:LOG_FRAC];
  logic        zero_e_r [1:LOG_FRAC];
  lane_ctl_t   ctl_e_r  [1:LOG_FRAC];

  for (genvar i = 1; i <= LOG_FRAC; i++) begin : g_exp
    logic [31:0] p_in;
    logic [27:0] w_in;
    logic        sat_in;
    logic        zero_in;
    lane_ctl_t   ctl_in;
    logic [63:0] prod;
    if (i == 1) begin : g_head
      assign p_in    = 32'd1 << 30;
      assign w_in    = w_r;
      assign sat_in  = sat_b_r;
      assign zero_in = zero_b_r;
      assign ctl_in  = ctl_b_r;
    end else begin : g_tail
      assign p_in    = p_r[i-1];
      assign w_in    = we_r[i-1];
      assign sat_in  = sat_e_r[i-1];
      assign zero_in = zero_e_r[i-1];
      assign ctl_in  = ctl_e_r[i-1];
    end
    assign prod = 64'(p_in) * 64'(ROOT_ROM[i]);
    always_ff @(posedge clk) begin
      p_r[i]      <= w_in[LOG_FRAC-i] ? prod[61:30] : p_in;
      we_r[i]     <= w_in;
      sat_e_r[i]  <= sat_in;
      zero_e_r[i] <= zero_in;
      ctl_e_r[i]  <= ctl_in;
    end
  end

  // Integer shift, clamp and special cases.
  logic [39:0] shifted;
  logic [9:0]  val;
  logic [CODE_W-1:0] code_nxt;
  logic [CODE_W-1:0] code_r;

  assign shifted = 40'(p_r[LOG_FRAC]) << we_r[LOG_FRAC][27:24];
  assign val = shifted[39:30];

  always_comb begin
    if (ctl_e_r[LOG_FRAC].force_en) begin
      code_nxt = ctl_e_r[LOG_FRAC].force_val ? 8'hFF : 8'h00;
    end else if (sat_e_r[LOG_FRAC]) begin
      code_nxt = 8'hFF;
    end else if (zero_e_r[LOG_FRAC]) begin
      code_nxt = 8'h00;
    end else if (val > 10'd255) begin
      code_nxt = 8'hFF;
    end else begin
      code_nxt = val[7:0];
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
  end

  assign code = code_r;

endmodule
